@@ rtl/ils_pkg.sv @@
// ils_pkg: shared types and constants for the indexed list store.
// Used by ils_ctrl, ils_dpath and indexed_list_store_core; no dependencies.
package ils_pkg;

  // Default list capacity in entries
  localparam int unsigned CAPACITY_DEF = 1024;

  // Fixed field widths of the command and result words
  localparam int unsigned CMD_W     = 4;
  localparam int unsigned POS_W     = 11;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CNT_OUT_W = 11;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    OP_PUSH_FRONT = 4'd0,
    OP_PUSH_BACK  = 4'd1,
    OP_INSERT     = 4'd2,
    OP_POP_FRONT  = 4'd3,
    OP_POP_BACK   = 4'd4,
    OP_REMOVE     = 4'd5,
    OP_READ       = 4'd6,
    OP_WRITE      = 4'd7,
    OP_CLEAR      = 4'd8
  } ils_op_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } ils_status_t;

  // Source of the working position latched with a command
  typedef enum logic [1:0] {
    POS_IN,
    POS_ZERO,
    POS_COUNT
  } ils_pos_sel_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP_OPEN,
    S_MOVE_OPEN,
    S_FILL,
    S_SETUP_CLOSE,
    S_MOVE_CLOSE,
    S_READ,
    S_WRITE,
    S_RESP
  } ils_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic         ld;          // latch the incoming word
    ils_pos_sel_t pos_sel;     // working position source on ld
    ils_status_t  st;          // status to report, on ld
    logic         rd_ok;       // result carries read data, on ld
    logic         cnt_inc;
    logic         cnt_dec;
    logic         cnt_clr;
    logic         setup_open;  // prepare a shift toward the back
    logic         setup_close; // prepare a shift toward the front
    logic         mv_step;     // one step of the shift engine
    logic         mv_open;     // shift direction: toward the back
    logic         wr_val;      // write latched value at working position
    logic         rd_pos;      // read entry at working position
    logic         out_load;    // load the result register
  } ils_ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic pos_le_cnt;  // incoming position <= count
    logic pos_lt_cnt;  // incoming position <  count
    logic more;        // shift moves remain
    logic out_free;    // result register can take a word
  } ils_stat_t;

endpackage

@@ rtl/ils_ctrl.sv @@
// ils_ctrl: command sequencer for the indexed list store.
// Depends on ils_pkg for state, command and status types.
module ils_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [ils_pkg::CMD_W-1:0] in_cmd,
  output logic                     in_stall,
  input  ils_pkg::ils_stat_t       stat,
  output ils_pkg::ils_ctl_t        ctl
);

  ils_pkg::ils_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ils_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Accept only when idle
  assign in_stall = (state_r != ils_pkg::S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    ctl.pos_sel = ils_pkg::POS_IN;
    ctl.st      = ils_pkg::ST_DONE;
    unique case (state_r)
      ils_pkg::S_IDLE: begin
        if (in_valid) begin
          ctl.ld    = 1'b1;
          state_nxt = ils_pkg::S_RESP;
          unique case (ils_pkg::ils_op_t'(in_cmd))
            ils_pkg::OP_PUSH_FRONT: begin
              if (stat.full) begin
                ctl.st = ils_pkg::ST_FULL;
              end else begin
                ctl.pos_sel = ils_pkg::POS_ZERO;
                state_nxt   = ils_pkg::S_SETUP_OPEN;
              end
            end
            ils_pkg::OP_PUSH_BACK: begin
              if (stat.full) begin
                ctl.st = ils_pkg::ST_FULL;
              end else begin
                ctl.pos_sel = ils_pkg::POS_COUNT;
                state_nxt   = ils_pkg::S_SETUP_OPEN;
              end
            end
            ils_pkg::OP_INSERT: begin
              if (!stat.pos_le_cnt) begin
                ctl.st = ils_pkg::ST_BAD;
              end else if (stat.full) begin
                ctl.st = ils_pkg::ST_FULL;
              end else begin
                state_nxt = ils_pkg::S_SETUP_OPEN;
              end
            end
            ils_pkg::OP_POP_FRONT: begin
              if (stat.empty) begin
                ctl.st = ils_pkg::ST_BAD;
              end else begin
                ctl.pos_sel = ils_pkg::POS_ZERO;
                state_nxt   = ils_pkg::S_SETUP_CLOSE;
              end
            end
            ils_pkg::OP_POP_BACK: begin
              if (stat.empty) begin
                ctl.st = ils_pkg::ST_BAD;
              end else begin
                ctl.cnt_dec = 1'b1;
              end
            end
            ils_pkg::OP_REMOVE: begin
              if (!stat.pos_lt_cnt) begin
                ctl.st = ils_pkg::ST_BAD;
              end else begin
                state_nxt = ils_pkg::S_SETUP_CLOSE;
              end
            end
            ils_pkg::OP_READ: begin
              if (!stat.pos_lt_cnt) begin
                ctl.st = ils_pkg::ST_BAD;
              end else begin
                ctl.rd_ok = 1'b1;
                state_nxt = ils_pkg::S_READ;
              end
            end
            ils_pkg::OP_WRITE: begin
              if (!stat.pos_lt_cnt) begin
                ctl.st = ils_pkg::ST_BAD;
              end else begin
                state_nxt = ils_pkg::S_WRITE;
              end
            end
            ils_pkg::OP_CLEAR: begin
              ctl.cnt_clr = 1'b1;
            end
            default: begin
              ctl.st = ils_pkg::ST_BAD;
            end
          endcase
        end
      end
      ils_pkg::S_SETUP_OPEN: begin
        ctl.setup_open = 1'b1;
        state_nxt      = ils_pkg::S_MOVE_OPEN;
      end
      ils_pkg::S_MOVE_OPEN: begin
        // Shift entries back by one, last move drains here too
        ctl.mv_step = 1'b1;
        ctl.mv_open = 1'b1;
        if (!stat.more) begin
          state_nxt = ils_pkg::S_FILL;
        end
      end
      ils_pkg::S_FILL: begin
        ctl.wr_val  = 1'b1;
        ctl.cnt_inc = 1'b1;
        state_nxt   = ils_pkg::S_RESP;
      end
      ils_pkg::S_SETUP_CLOSE: begin
        ctl.setup_close = 1'b1;
        state_nxt       = ils_pkg::S_MOVE_CLOSE;
      end
      ils_pkg::S_MOVE_CLOSE: begin
        ctl.mv_step = 1'b1;
        if (!stat.more) begin
          ctl.cnt_dec = 1'b1;
          state_nxt   = ils_pkg::S_RESP;
        end
      end
      ils_pkg::S_READ: begin
        ctl.rd_pos = 1'b1;
        state_nxt  = ils_pkg::S_RESP;
      end
      ils_pkg::S_WRITE: begin
        ctl.wr_val = 1'b1;
        state_nxt  = ils_pkg::S_RESP;
      end
      ils_pkg::S_RESP: begin
        // Hold until the result register frees up
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = ils_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ils_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/ils_dpath.sv @@
// ils_dpath: entry memory, count, shift engine and result register.
// Depends on ils_pkg for the command and status structs.
module ils_dpath #(
  parameter int unsigned CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic        [ils_pkg::POS_W-1:0]     in_position,
  input  logic signed [ils_pkg::VAL_W-1:0]     in_value_in,
  input  ils_pkg::ils_ctl_t                   ctl,
  output ils_pkg::ils_stat_t                  stat,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ils_pkg::VAL_W-1:0]     out_read_value,
  output logic        [ils_pkg::STAT_W-1:0]    out_status,
  output logic        [ils_pkg::CNT_OUT_W-1:0] out_element_count,
  output logic                                out_is_empty
);

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CMP_W  = (CNT_W > ils_pkg::POS_W) ? CNT_W : ils_pkg::POS_W;

  // Entry memory
  logic signed [ils_pkg::VAL_W-1:0] mem [CAPACITY];
  logic signed [ils_pkg::VAL_W-1:0] rdata_r;
  logic                             mem_we, mem_re;
  logic        [ADDR_W-1:0]         mem_waddr, mem_raddr;
  logic signed [ils_pkg::VAL_W-1:0] mem_wdata;

  // Command context
  logic        [CNT_W-1:0]          count_r;
  logic        [CNT_W-1:0]          pos_r;
  logic signed [ils_pkg::VAL_W-1:0] val_r;
  ils_pkg::ils_status_t             st_r;
  logic                             rd_ok_r;

  // Shift engine
  logic [ADDR_W-1:0] src_r;
  logic [CNT_W-1:0]  n_r;
  logic              mv_pend_r;
  logic [ADDR_W-1:0] mv_dst_r;

  // Result register
  logic                                out_valid_r;
  logic signed [ils_pkg::VAL_W-1:0]     out_read_value_r;
  logic        [ils_pkg::STAT_W-1:0]    out_status_r;
  logic        [ils_pkg::CNT_OUT_W-1:0] out_element_count_r;
  logic                                out_is_empty_r;

  logic [CMP_W-1:0]  pos_ext, cnt_ext;
  logic [CNT_W-1:0]  pos_sel_val;
  logic [CNT_W-1:0]  cnt_m1, pos_p1, open_n, close_n;
  logic [ADDR_W-1:0] pos_idx;

  assign pos_ext = CMP_W'(in_position);
  assign cnt_ext = CMP_W'(count_r);
  assign pos_idx = pos_r[ADDR_W-1:0];
  assign cnt_m1  = count_r - CNT_W'(1);
  assign pos_p1  = pos_r + CNT_W'(1);
  assign open_n  = count_r - pos_r;
  assign close_n = cnt_m1 - pos_r;

  // Status toward the controller
  assign stat.empty      = (count_r == '0);
  assign stat.full       = (count_r == CNT_W'(CAPACITY));
  assign stat.pos_le_cnt = (pos_ext <= cnt_ext);
  assign stat.pos_lt_cnt = (pos_ext < cnt_ext);
  assign stat.more       = (n_r != '0);
  assign stat.out_free   = !out_valid_r || !out_stall;

  // Select working position
  always_comb begin
    case (ctl.pos_sel)
      ils_pkg::POS_ZERO:  pos_sel_val = '0;
      ils_pkg::POS_COUNT: pos_sel_val = count_r;
      default:            pos_sel_val = pos_ext[CNT_W-1:0];
    endcase
  end

  // Memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = mv_dst_r;
    mem_wdata = rdata_r;
    mem_re    = 1'b0;
    mem_raddr = src_r;
    if (ctl.mv_step) begin
      mem_we = mv_pend_r;
      mem_re = (n_r != '0);
    end
    if (ctl.wr_val) begin
      mem_we    = 1'b1;
      mem_waddr = pos_idx;
      mem_wdata = val_r;
    end
    if (ctl.rd_pos) begin
      mem_re    = 1'b1;
      mem_raddr = pos_idx;
    end
  end

  // Memory array, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // Latch command context
  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      pos_r   <= pos_sel_val;
      val_r   <= in_value_in;
      st_r    <= ctl.st;
      rd_ok_r <= ctl.rd_ok;
    end
  end

  // Element count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.cnt_clr) begin
      count_r <= '0;
    end else if (ctl.cnt_inc) begin
      count_r <= count_r + CNT_W'(1);
    end else if (ctl.cnt_dec) begin
      count_r <= cnt_m1;
    end
  end

  // Shift engine: read one entry per cycle, write it one place over next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_pend_r <= 1'b0;
      n_r       <= '0;
    end else if (ctl.setup_open) begin
      n_r       <= open_n;
      src_r     <= cnt_m1[ADDR_W-1:0];
      mv_pend_r <= 1'b0;
    end else if (ctl.setup_close) begin
      n_r       <= close_n;
      src_r     <= pos_p1[ADDR_W-1:0];
      mv_pend_r <= 1'b0;
    end else if (ctl.mv_step) begin
      if (n_r != '0) begin
        n_r       <= n_r - CNT_W'(1);
        mv_pend_r <= 1'b1;
        if (ctl.mv_open) begin
          mv_dst_r <= src_r + ADDR_W'(1);
          src_r    <= src_r - ADDR_W'(1);
        end else begin
          mv_dst_r <= src_r - ADDR_W'(1);
          src_r    <= src_r + ADDR_W'(1);
        end
      end else begin
        mv_pend_r <= 1'b0;
      end
    end
  end

  // Result valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_read_value_r    <= rd_ok_r ? rdata_r : '0;
      out_status_r        <= st_r;
      out_element_count_r <= cnt_ext[ils_pkg::CNT_OUT_W-1:0];
      out_is_empty_r      <= (count_r == '0);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_value    = out_read_value_r;
  assign out_status        = out_status_r;
  assign out_element_count = out_element_count_r;
  assign out_is_empty      = out_is_empty_r;

endmodule

@@ rtl/indexed_list_store_core.sv @@
// indexed_list_store_core: top level of the indexed list store.
// Depends on ils_pkg, ils_ctrl and ils_dpath.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall   cmd, position, value_in
//   out_     output     out_valid/out_stall read_value, status, element_count, is_empty
//
// One word is worked at a time; in_stall is low only while the sequencer is idle.
// Rejected words, pop back and clear go from idle to the response state; read and
// write pass a read or write state first; push and insert pass setup, move and fill,
// pop front and remove setup and move, the shift engine moving one entry per memory
// cycle. The next word can be taken in the cycle after the result register loads.
// Reset (rst_n low, synchronous) empties the list; memory contents are not cleared.
// A stalled result holds in its register while the next word may already be taken.
module indexed_list_store_core #(
  parameter int unsigned CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic        [ils_pkg::CMD_W-1:0]     in_cmd,
  input  logic        [ils_pkg::POS_W-1:0]     in_position,
  input  logic signed [ils_pkg::VAL_W-1:0]     in_value_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ils_pkg::VAL_W-1:0]     out_read_value,
  output logic        [ils_pkg::STAT_W-1:0]    out_status,
  output logic        [ils_pkg::CNT_OUT_W-1:0] out_element_count,
  output logic                                out_is_empty
);

  ils_pkg::ils_ctl_t  ctl;
  ils_pkg::ils_stat_t stat;

  // Sequencer
  ils_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Storage and result path
  ils_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_position       (in_position),
    .in_value_in       (in_value_in),
    .ctl               (ctl),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_value    (out_read_value),
    .out_status        (out_status),
    .out_element_count (out_element_count),
    .out_is_empty      (out_is_empty)
  );

endmodule
